>>> rtl/core/sfsp_pkg.sv
// ----------------------------------------------------------------------------
// sfsp_pkg
// Shared types, codes and helpers for the fling scroll physics block.
// ----------------------------------------------------------------------------
package sfsp_pkg;

  localparam int SNAP_POINTS_DEF = 16;

  localparam int POS_W   = 24;
  localparam int SPD_W   = 32;
  localparam int ACC_W   = 32;
  localparam int DT_W    = 16;
  localparam int FRIC_W  = 16;
  localparam int KIND_W  = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // shared multiplier: signed A times unsigned B
  localparam int MA_W = 33;
  localparam int MB_W = 25;
  localparam int PR_W = MA_W + MB_W + 1;

  // iterative divider
  localparam int DIV_W  = 40;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int REM_W  = FRIC_W + 1;

  localparam int END_W  = 42;
  localparam int DIST_W = END_W + 1;

  localparam logic [FRIC_W-1:0] FRIC_RESET  = 16'd2048;
  localparam logic [ACC_W-1:0]  SEED_MIN    = 32'd25600;
  localparam logic [FRIC_W-1:0] SEED_DIV    = 16'd3125;
  // floor(2^36 / 3125): quotient estimate is (x >> 5) * SEED_RECIP >> 31,
  // at most one below the true quotient for any 35-bit x
  localparam logic [MB_W-1:0]   SEED_RECIP  = 25'd21990232;
  localparam int                SEED_PRE    = 5;
  localparam int                SEED_SHIFT  = 31;
  localparam int                SETTLE_MIN  = 1280;
  localparam int                STOP_DIST   = 25;
  localparam int                EASE_RATE   = 15;
  localparam int                EASE_ONE    = 65536;
  localparam int                K_ONE       = 1 << 24;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_START = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    REG_FRICTION = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_DIVEND,
    ST_START2,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SNAPSET,
    ST_MUL,
    ST_RND,
    ST_APPLY,
    ST_TICKK,
    ST_SEEDFIX,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_SEED,
    OP_END,
    OP_SNAP,
    OP_TPOS,
    OP_TK,
    OP_TSPD,
    OP_EASE
  } op_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd8388607;
    lo = -64'sd8388608;
    if (v > hi) sat_pos = POS_W'(hi);
    else if (v < lo) sat_pos = POS_W'(lo);
    else sat_pos = POS_W'(v);
  endfunction

  function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) sat_spd = SPD_W'(hi);
    else if (v < lo) sat_spd = SPD_W'(lo);
    else sat_spd = SPD_W'(v);
  endfunction

endpackage

>>> rtl/core/scroll_fling_snap_physics_top.sv
// ----------------------------------------------------------------------------
// scroll_fling_snap_physics_top
// Fixed point fling scroll simulator with snap points.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per item: clear snap
// points, add a snap point, start a fling, or a time tick. Each item yields
// exactly one result word on the output channel (out_valid/out_ready) with
// the position after the item, the moving flag and the stopped flag.
// The block works on one item at a time with a small sequencer around one
// shared multiplier and one bit-serial divider for the divide by friction:
//   clear / add : update the snap count, then report
//   tick        : moving, easing toward the target, or landing on it
//   start       : a weak fling starts at rest and a strong one is seeded
//                 from the reciprocal (seed plus one correction step); with
//                 stored points this is followed by one 40-step divide plus
//                 a walk over every snap point
// in_ready is high only while the sequencer idles, so an item is taken only
// once the last one is through. The result sits in an output register, so
// the next item is accepted while a result still waits; the sequencer holds
// in its final step if the receiver stalls with a word already pending.
// Friction is written through the APB-style port at byte address 0 and may
// be changed only while the block is idle. Synchronous reset returns
// position, speed, targets and snap count to zero, friction to 8.0 and sets
// stopped; snap point storage is not cleared.
// ----------------------------------------------------------------------------
module scroll_fling_snap_physics_top #(
  parameter int SNAP_POINTS = sfsp_pkg::SNAP_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sfsp_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [sfsp_pkg::POS_W-1:0]   in_position_value,
  input  logic signed [sfsp_pkg::POS_W-1:0]   in_scroll_range,
  input  logic signed [sfsp_pkg::ACC_W-1:0]   in_fling_acceleration,
  input  logic [sfsp_pkg::DT_W-1:0]           in_elapsed_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sfsp_pkg::POS_W-1:0]   out_position,
  output logic                                out_moving,
  output logic                                out_stopped,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sfsp_pkg::CFG_AW-1:0]         paddr,
  input  logic [sfsp_pkg::CFG_DW-1:0]         pwdata,
  output logic [sfsp_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);
  import sfsp_pkg::*;

  localparam int CNT_W = $clog2(SNAP_POINTS + 1);
  localparam int IDX_W = (SNAP_POINTS > 1) ? $clog2(SNAP_POINTS) : 1;

  // ---- state ---------------------------------------------------------------
  state_t                    state_r, state_nxt;
  op_t                       op_r, op_nxt;
  logic [FRIC_W-1:0]         friction_r;
  logic signed [POS_W-1:0]   pos_r, pos_nxt;
  logic signed [SPD_W-1:0]   speed_r, speed_nxt;
  logic signed [POS_W-1:0]   target_r, target_nxt;
  logic signed [POS_W-1:0]   limit_r, limit_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      halted_r, halted_nxt;

  // item latch
  kind_t                     kind_r;
  logic signed [POS_W-1:0]   pv_r;
  logic signed [POS_W-1:0]   rg_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [DT_W-1:0]           dt_r;

  // shared multiplier and rounding
  logic signed [MA_W-1:0]    mul_a_r, mul_a_nxt;
  logic [MB_W-1:0]           mul_b_r, mul_b_nxt;
  logic signed [PR_W-1:0]    prod_r, prod_nxt;
  logic signed [PR_W-1:0]    rq_r, rq_nxt;

  // divider
  logic [DIV_W-1:0]          dq_r, dq_nxt;
  logic [REM_W-1:0]          drem_r, drem_nxt;
  logic [FRIC_W-1:0]         dd_r, dd_nxt;
  logic [DCNT_W-1:0]         dcnt_r, dcnt_nxt;

  // snap walk
  logic signed [END_W-1:0]   end_r, end_nxt;
  logic [DIST_W-1:0]         best_r, best_nxt;
  logic signed [POS_W-1:0]   pick_r, pick_nxt;
  logic                      have_r, have_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [POS_W-1:0]   snap_mem [SNAP_POINTS];
  logic signed [POS_W-1:0]   rd_r;
  logic                      mem_we;

  // output word
  logic                      out_valid_r;
  logic signed [POS_W-1:0]   out_pos_r;
  logic                      out_mov_r;
  logic                      out_stp_r;
  logic                      out_load;

  // ---- configuration port --------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_FRICTION) ? CFG_DW'(friction_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r <= FRIC_RESET;
    end else if (cfg_wr && reg_idx_t'(paddr[2]) == REG_FRICTION) begin
      friction_r <= pwdata[FRIC_W-1:0];
    end
  end

  // ---- shared combinational terms ------------------------------------------
  logic [FRIC_W-1:0]         fric;
  logic [ACC_W-1:0]          acc_mag;
  logic                      seed_big;
  logic [DIV_W-1:0]          seed_x;
  logic [DIV_W-1:0]          seed_qx;
  logic                      seed_up;
  logic [SPD_W-1:0]          spd_mag;
  logic signed [POS_W:0]     diff;
  logic [POS_W:0]            diff_mag;
  logic                      near;
  logic [20:0]               ease_raw;
  logic [MB_W-1:0]           ease_k;
  logic [REM_W-1:0]          drem_sh;
  logic                      dfit;
  logic signed [DIST_W-1:0]  sd;
  logic [DIST_W-1:0]         sd_mag;
  logic                      scan_last;
  logic                      overscr;
  logic                      prod_neg;
  logic [PR_W-1:0]           prod_mag;
  logic [PR_W-1:0]           rsum;
  logic [PR_W-1:0]           rshift;

  assign fric     = (friction_r == '0) ? FRIC_W'(1) : friction_r;
  assign acc_mag  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign seed_big = acc_mag > SEED_MIN;
  // seed dividend with the half-divisor already added for rounding
  assign seed_x   = DIV_W'({acc_mag, 3'b000}) + DIV_W'(SEED_DIV >> 1);
  // quotient estimate times the divisor; bump the estimate when one more fits
  assign seed_qx  = dq_r * DIV_W'(SEED_DIV);
  assign seed_up  = seed_x >= (seed_qx + DIV_W'(SEED_DIV));
  assign spd_mag  = speed_r[SPD_W-1] ? SPD_W'(-speed_r) : SPD_W'(speed_r);
  assign diff     = (POS_W+1)'(target_r) - (POS_W+1)'(pos_r);
  assign diff_mag = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
  assign near     = diff_mag <= (POS_W+1)'(STOP_DIST);
  assign ease_raw = 21'(dt_r) * 21'(EASE_RATE);
  assign ease_k   = (ease_raw > 21'(EASE_ONE)) ? MB_W'(EASE_ONE) : MB_W'(ease_raw);

  // one restoring step per cycle
  assign drem_sh  = {drem_r[REM_W-2:0], dq_r[DIV_W-1]};
  assign dfit     = drem_sh >= REM_W'(dd_r);

  assign sd        = DIST_W'(rd_r) - DIST_W'(end_r);
  assign sd_mag    = sd[DIST_W-1] ? DIST_W'(-sd) : DIST_W'(sd);
  assign scan_last = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;

  assign overscr  = (pos_r < limit_r) || (pos_r > 0);

  // round-half-away division of the product by 2^8, 2^16 or 2^24
  assign prod_neg = prod_r[PR_W-1];
  assign prod_mag = prod_neg ? PR_W'(-prod_r) : PR_W'(prod_r);
  always_comb begin
    case (op_r)
      OP_SNAP:  rsum = prod_mag + (PR_W'(1) << 7);
      OP_TSPD:  rsum = prod_mag + (PR_W'(1) << 23);
      default:  rsum = prod_mag + (PR_W'(1) << 15);
    endcase
    case (op_r)
      OP_SNAP:  rshift = rsum >> 8;
      OP_TSPD:  rshift = rsum >> 24;
      default:  rshift = rsum >> 16;
    endcase
  end

  // ---- next state ----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        case (kind_r)
          KIND_START: state_nxt = seed_big ? ST_MUL : ST_START2;
          KIND_TICK:  state_nxt = (speed_r != 0 || !near) ? ST_MUL : ST_DONE;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_DIV:      if (dcnt_r == DCNT_W'(DIV_W - 1)) state_nxt = ST_DIVEND;
      ST_DIVEND:   state_nxt = ST_SCAN_RD;
      ST_START2:   state_nxt = (cnt_r != '0) ? ST_DIV : ST_DONE;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: state_nxt = scan_last ? ST_SNAPSET : ST_SCAN_RD;
      ST_SNAPSET:  state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_RND;
      ST_RND:      state_nxt = ST_APPLY;
      ST_APPLY: begin
        case (op_r)
          OP_SEED: state_nxt = ST_SEEDFIX;
          OP_TPOS: state_nxt = ST_TICKK;
          OP_TK:   state_nxt = ST_MUL;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_TICKK:    state_nxt = ST_MUL;
      ST_SEEDFIX:  state_nxt = ST_START2;
      ST_DONE:     if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---- datapath updates ----------------------------------------------------
  always_comb begin
    logic signed [63:0]       wide;
    logic signed [SPD_W+1:0]  sn;
    logic [SPD_W+1:0]         sn_mag;
    logic signed [DIV_W:0]    qs;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    speed_nxt  = speed_r;
    target_nxt = target_r;
    limit_nxt  = limit_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    mul_a_nxt  = mul_a_r;
    mul_b_nxt  = mul_b_r;
    prod_nxt   = prod_r;
    rq_nxt     = rq_r;
    dq_nxt     = dq_r;
    drem_nxt   = drem_r;
    dd_nxt     = dd_r;
    dcnt_nxt   = dcnt_r;
    end_nxt    = end_r;
    best_nxt   = best_r;
    pick_nxt   = pick_r;
    have_nxt   = have_r;
    idx_nxt    = idx_r;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    wide       = '0;
    sn         = '0;
    sn_mag     = '0;
    qs         = '0;
    case (state_r)
      ST_DISPATCH: begin
        case (kind_r)
          KIND_CLEAR: cnt_nxt = '0;
          KIND_ADD: begin
            if (cnt_r < CNT_W'(SNAP_POINTS)) begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          KIND_START: begin
            if (seed_big) begin
              // estimate the seed quotient through the shared multiplier
              op_nxt    = OP_SEED;
              mul_a_nxt = MA_W'(seed_x[DIV_W-1:SEED_PRE]);
              mul_b_nxt = SEED_RECIP;
            end else begin
              speed_nxt = '0;
            end
          end
          default: begin
            if (speed_r != 0) begin
              op_nxt    = OP_TPOS;
              mul_a_nxt = MA_W'(speed_r);
              mul_b_nxt = MB_W'(dt_r);
            end else if (near) begin
              pos_nxt    = target_r;
              halted_nxt = 1'b1;
            end else begin
              op_nxt    = OP_EASE;
              mul_a_nxt = MA_W'(diff);
              mul_b_nxt = ease_k;
            end
          end
        endcase
      end
      ST_DIV: begin
        dq_nxt   = {dq_r[DIV_W-2:0], dfit};
        drem_nxt = dfit ? drem_sh - REM_W'(dd_r) : drem_sh;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
      end
      ST_DIVEND: begin
        qs       = speed_r[SPD_W-1] ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
        end_nxt  = -(END_W'(pos_r) + END_W'(qs));
        idx_nxt  = '0;
        have_nxt = 1'b0;
      end
      ST_START2: begin
        limit_nxt  = rg_r;
        target_nxt = (pv_r < rg_r) ? rg_r : ((pv_r > 0) ? '0 : pv_r);
        pos_nxt    = pv_r;
        halted_nxt = 1'b0;
        op_nxt     = OP_END;
        dq_nxt     = DIV_W'({spd_mag, 8'h00}) + DIV_W'(fric >> 1);
        dd_nxt     = fric;
        drem_nxt   = '0;
        dcnt_nxt   = '0;
      end
      ST_SCAN_CMP: begin
        if (!have_r || sd_mag < best_r) begin
          have_nxt = 1'b1;
          best_nxt = sd_mag;
          pick_nxt = rd_r;
        end
        idx_nxt = idx_r + IDX_W'(1);
      end
      ST_SNAPSET: begin
        op_nxt    = OP_SNAP;
        mul_a_nxt = -(MA_W'(pick_r) + MA_W'(pos_r));
        mul_b_nxt = MB_W'(fric);
      end
      ST_MUL: prod_nxt = PR_W'(mul_a_r * $signed({1'b0, mul_b_r}));
      ST_RND: rq_nxt = prod_neg ? -$signed(rshift) : $signed(rshift);
      ST_APPLY: begin
        case (op_r)
          OP_SEED: dq_nxt = DIV_W'(prod_r[PR_W-1:SEED_SHIFT]);
          OP_SNAP: speed_nxt = sat_spd(64'(rq_r));
          OP_TPOS: begin
            wide    = 64'(pos_r) + 64'(rq_r);
            pos_nxt = sat_pos(wide);
          end
          OP_TK: begin
            op_nxt    = OP_TSPD;
            mul_a_nxt = MA_W'(speed_r);
            mul_b_nxt = (prod_r > PR_W'(K_ONE)) ? MB_W'(K_ONE) : MB_W'(prod_r);
          end
          OP_TSPD: begin
            sn     = (SPD_W+2)'(speed_r) - (SPD_W+2)'(rq_r);
            sn_mag = sn[SPD_W+1] ? (SPD_W+2)'(-sn) : (SPD_W+2)'(sn);
            if (sn_mag < (SPD_W+2)'(SETTLE_MIN)) begin
              speed_nxt  = '0;
              target_nxt = (pos_r < limit_r) ? limit_r : ((pos_r > 0) ? '0 : pos_r);
            end else begin
              speed_nxt = SPD_W'(sn);
            end
          end
          default: begin
            wide    = 64'(pos_r) + 64'(rq_r);
            pos_nxt = sat_pos(wide);
          end
        endcase
      end
      ST_TICKK: begin
        // quadruple friction while outside the range
        op_nxt    = OP_TK;
        mul_a_nxt = MA_W'(dt_r);
        mul_b_nxt = overscr ? MB_W'({fric, 2'b00}) : MB_W'(fric);
      end
      ST_SEEDFIX: begin
        // the estimate is at most one low; apply the sign of the fling
        speed_nxt = acc_r[ACC_W-1] ? -SPD_W'(dq_r + DIV_W'(seed_up))
                                   : SPD_W'(dq_r + DIV_W'(seed_up));
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      speed_r     <= '0;
      target_r    <= '0;
      limit_r     <= '0;
      cnt_r       <= '0;
      halted_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      speed_r  <= speed_nxt;
      target_r <= target_nxt;
      limit_r  <= limit_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= kind_t'(in_kind);
      pv_r   <= in_position_value;
      rg_r   <= in_scroll_range;
      acc_r  <= in_fling_acceleration;
      dt_r   <= in_elapsed_time;
    end
    op_r    <= op_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    prod_r  <= prod_nxt;
    rq_r    <= rq_nxt;
    dq_r    <= dq_nxt;
    drem_r  <= drem_nxt;
    dd_r    <= dd_nxt;
    dcnt_r  <= dcnt_nxt;
    end_r   <= end_nxt;
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    have_r  <= have_nxt;
    idx_r   <= idx_nxt;
    if (out_load) begin
      out_pos_r <= pos_r;
      out_mov_r <= (speed_r != 0);
      out_stp_r <= halted_r;
    end
  end

  // snap point store: append at the fill count, read at the walk index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      snap_mem[cnt_r[IDX_W-1:0]] <= pv_r;
    end
    rd_r <= snap_mem[idx_r];
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_moving   = out_mov_r;
  assign out_stopped  = out_stp_r;

  // ---- assertions ----------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after accept");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SNAP_POINTS))
    else $error("snap count beyond store depth");

  a_halted_still: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && state_r == ST_IDLE |-> speed_r == 0)
    else $error("stopped while speed is nonzero");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dcnt_r < DCNT_W'(DIV_W))
    else $error("divider step count overrun");

endmodule
